[design/elal_pkg.sv]
// shared constants, atan table and unit handshake types for the ellipse arc length block
// imported by elal_mul, elal_div, elal_cordic and ellipse_arc_length
`timescale 1ns / 1ps
package elal_pkg;

  localparam int MAX_SERIES_TERMS  = 64;
  localparam int CORDIC_ITERATIONS = 24;
  localparam int ATAN_LEN          = 48;
  localparam int ATAN_IW           = $clog2(ATAN_LEN);
  localparam int CITER_W           = $clog2(CORDIC_ITERATIONS);
  localparam int TERM_W            = $clog2(MAX_SERIES_TERMS + 1);
  localparam int DIV_W             = 64;
  localparam int DCNT_W            = $clog2(DIV_W);
  localparam int CW                = 50;  // cordic x/y width
  localparam int ZW                = 34;  // cordic angle width
  localparam int CFG_IDX_W         = 8;

  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [30:0] TWO_PI_Q28   = 31'd1686629713;
  localparam logic [24:0] DEG_Q30      = 25'd18740330;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [37:0] LEN_ONE      = 38'd65536;
  localparam logic [12:0] STEPS_RESET  = 13'd1000;
  localparam logic [15:0] TOL_RESET    = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 8'd1;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [29:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic [29:0] v;
    case (idx)
      6'd0:  v = 30'd843314856;
      6'd1:  v = 30'd497837829;
      6'd2:  v = 30'd263043836;
      6'd3:  v = 30'd133525158;
      6'd4:  v = 30'd67021686;
      6'd5:  v = 30'd33543515;
      6'd6:  v = 30'd16775850;
      6'd7:  v = 30'd8388437;
      6'd8:  v = 30'd4194282;
      6'd9:  v = 30'd2097149;
      6'd10: v = 30'd1048575;
      6'd11: v = 30'd524287;
      6'd12: v = 30'd262143;
      6'd13: v = 30'd131071;
      6'd14: v = 30'd65535;
      6'd15: v = 30'd32767;
      6'd16: v = 30'd16383;
      6'd17: v = 30'd8191;
      6'd18: v = 30'd4095;
      6'd19: v = 30'd2047;
      6'd20: v = 30'd1023;
      6'd21: v = 30'd511;
      6'd22: v = 30'd255;
      6'd23: v = 30'd127;
      6'd24: v = 30'd63;
      6'd25: v = 30'd31;
      6'd26: v = 30'd15;
      6'd27: v = 30'd8;
      6'd28: v = 30'd4;
      6'd29: v = 30'd2;
      6'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[design/elal_mul.sv]
// shared 32x32 unsigned multiplier with registered product
// imports elal_pkg but uses none of its items
`timescale 1ns / 1ps
module elal_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  import elal_pkg::*;

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

[design/elal_div.sv]
// shared restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// depends on elal_pkg for widths and the status struct
`timescale 1ns / 1ps
module elal_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             dividend_i,
  input  logic [31:0]             divisor_i,
  output elal_pkg::unit_stat_t    stat_o,
  output logic [63:0]             quot_o
);
  import elal_pkg::*;

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [63:0]       quo_q;
  logic [31:0]       rem_q, dvs_q;
  logic [32:0]       trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

[design/elal_cordic.sv]
// iterative cordic, rotation mode for sin/cos and vectoring mode for magnitude/atan
// depends on elal_pkg for the atan table, widths and control structs
`timescale 1ns / 1ps
module elal_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  elal_pkg::cordic_ctrl_t       ctrl_i,
  input  logic signed [elal_pkg::CW-1:0] x0_i,
  input  logic signed [elal_pkg::CW-1:0] y0_i,
  input  logic signed [elal_pkg::ZW-1:0] z0_i,
  output elal_pkg::unit_stat_t         stat_o,
  output logic signed [elal_pkg::CW-1:0] x_o,
  output logic signed [elal_pkg::CW-1:0] y_o,
  output logic signed [elal_pkg::ZW-1:0] z_o
);
  import elal_pkg::*;

  logic               busy_q, done_q, vec_q;
  logic [CITER_W-1:0] cnt_q;
  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, at;
  logic                 up;

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    at = signed'({{(ZW-30){1'b0}}, atan_q30(ATAN_IW'(cnt_q))});
    // vectoring drives y toward zero, rotation drives z toward zero
    up = vec_q ? !y_q[CW-1] : z_q[ZW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vec_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      vec_q  <= ctrl_i.vec_mode;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CITER_W'(CORDIC_ITERATIONS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= z0_i;
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[design/ellipse_arc_length.sv]
// ellipse arc length top level: sequencer around a shared multiplier, divider and cordic
// depends on elal_pkg, elal_mul, elal_div and elal_cordic
//
//  channel | direction | handshake             | payload
//  in      | request   | in_valid_i/in_ready_o | semi_major_i, semi_minor_i, sweep_degrees_i
//  out     | result    | out_valid_o/out_ready_i | arc_length_o, axes_invalid_o
//  cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one request at a time; in_ready_o is high only while the sequencer is idle
// work: perimeter setup, then three divides per series term,
// plus one divide and two 24-step cordic passes per integration step
// and the arc setup and final scaling; invalid axes go straight to the output register
// a finished result sits in the output register while the next request is taken
// reset clears the control state and loads steps 1000 and tolerance 1
`timescale 1ns / 1ps
module ellipse_arc_length (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        semi_major_i,
  input  logic [31:0]                        semi_minor_i,
  input  logic [8:0]                         sweep_degrees_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [37:0]                        arc_length_o,
  output logic                               axes_invalid_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [elal_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import elal_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_PC, S_PC2, S_PR, S_PR2, S_PR3,
    S_P1, S_P1W, S_P1D, S_P2, S_P2W, S_P2D,
    S_E, S_EW, S_PE, S_PEW, S_T1, S_T1W, S_T2W, S_TD,
    S_DISP, S_QA, S_QAW, S_ROT, S_QB, S_QBW, S_QBX, S_VEC,
    S_K, S_KW, S_KD, S_KR, S_M, S_M2, S_M3,
    S_F, S_FD, S_F1, S_F2, S_F3, S_FIN, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    R_ZERO, R_ARC1, R_Q90, R_ARC2, R_H180, R_ARC3, R_Q270, R_ARC4, R_FULL
  } region_e;

  state_e  state_q;
  region_e region_q;

  logic [12:0] steps_q;
  logic [15:0] tol_q;

  logic [31:0] a_q, b_q;
  logic [8:0]  deg_q;
  logic        inv_q, first_q;
  logic [34:0] c_q, per_q;
  logic [29:0] r_q, tlo_q, mlo_q;
  logic [30:0] e2_q, p_q, epow_q, f_q, t_q, cos_q, sin_q, ang_q, flo_q;
  logic [TERM_W-1:0] i_q;
  logic [6:0]  qd_q;
  logic [46:0] vx_q;
  logic [12:0] k_q;
  logic [63:0] sum_q, sq_q;
  logic [49:0] arc_q;
  logic [37:0] len_q;
  logic        out_valid_q;
  logic [37:0] out_len_q;
  logic        out_inv_q;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start;
  logic [63:0] div_dividend, div_quot;
  logic [31:0] div_divisor;
  unit_stat_t  div_st, cor_st;
  cordic_ctrl_t cor_ctrl;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;

  logic [12:0]       n_w;
  logic [13:0]       two_n;
  logic [TERM_W:0]   two_i;
  logic [TERM_W-1:0] two_i_m1;
  logic [36:0]       mq;
  logic [35:0]       term;
  logic [30:0]       cos_c, sin_c, t_c;
  logic [63:0]       mag;
  logic [49:0]       q50, per50, mir50, len50;
  logic              x_pos;

  elal_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  elal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_st),
    .quot_o     (div_quot)
  );

  elal_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cor_ctrl),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .stat_o (cor_st),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  always_comb begin
    n_w      = (steps_q == 13'd0) ? 13'd1 : steps_q;
    two_n    = {n_w, 1'b0};
    two_i    = {i_q, 1'b0};
    two_i_m1 = TERM_W'(two_i - 1'b1);
    mq       = 37'(prod[35:0]) + 37'(tlo_q);
    term     = div_quot[35:0];
    cos_c = cor_x[CW-1] ? 31'd0 :
            (cor_x[CW-2:0] > (CW-1)'(ONE_Q30)) ? ONE_Q30 : cor_x[30:0];
    sin_c = cor_y[CW-1] ? 31'd0 :
            (cor_y[CW-2:0] > (CW-1)'(ONE_Q30)) ? ONE_Q30 : cor_y[30:0];
    t_c   = cor_z[ZW-1] ? 31'd0 :
            (cor_z[ZW-2:0] > (ZW-1)'(HALF_PI_Q30)) ? HALF_PI_Q30 : cor_z[30:0];
    x_pos = !cor_x[CW-1] && (cor_x != '0);
    mag   = x_pos ? (prod + 64'(mlo_q)) : 64'd0;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PC:  begin mul_a = a_q;                 mul_b = 32'(TWO_PI_Q28);   end
      S_PR2: begin mul_a = 32'(r_q);            mul_b = 32'(r_q);          end
      S_P1,
      S_P2:  begin mul_a = 32'(p_q);            mul_b = 32'(two_i_m1);     end
      S_E:   begin mul_a = 32'(epow_q);         mul_b = 32'(e2_q);         end
      S_PE:  begin mul_a = 32'(p_q);            mul_b = 32'(epow_q);       end
      S_T1:  begin mul_a = 32'(c_q[29:0]);      mul_b = 32'(f_q);          end
      S_T1W: begin mul_a = 32'(c_q[34:30]);     mul_b = 32'(f_q);          end
      S_QA:  begin mul_a = 32'(qd_q);           mul_b = 32'(DEG_Q30);      end
      S_QB:  begin mul_a = b_q;                 mul_b = 32'(cos_q);        end
      S_QBW: begin mul_a = a_q;                 mul_b = 32'(sin_q);        end
      S_K:   begin mul_a = 32'({k_q, 1'b1});    mul_b = 32'(t_q);          end
      S_M:   begin mul_a = 32'(cor_x[29:0]);    mul_b = 32'(INV_GAIN_Q30); end
      S_M2:  begin mul_a = 32'(cor_x[CW-2:30]); mul_b = 32'(INV_GAIN_Q30); end
      S_F1:  begin mul_a = 32'(sq_q[29:0]);     mul_b = 32'(t_q);          end
      S_F2:  begin mul_a = sq_q[61:30];         mul_b = 32'(t_q);          end
      default: begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  // divider requests
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 32'd1;
    case (state_q)
      S_PC2: begin
        div_start = 1'b1; div_dividend = {2'b00, b_q, 30'd0}; div_divisor = a_q;
      end
      S_P1W, S_P2W: begin
        div_start = 1'b1; div_dividend = prod; div_divisor = 32'(two_i);
      end
      S_T2W: begin
        div_start = 1'b1; div_dividend = 64'(mq); div_divisor = 32'(two_i_m1);
      end
      S_KW: begin
        div_start = 1'b1; div_dividend = prod; div_divisor = 32'(two_n);
      end
      S_F: begin
        div_start = 1'b1; div_dividend = sum_q; div_divisor = 32'(n_w);
      end
      default: begin
        div_start = 1'b0; div_dividend = '0; div_divisor = 32'd1;
      end
    endcase
  end

  // cordic requests
  always_comb begin
    cor_ctrl = '0;
    cor_x0   = signed'(CW'(INV_GAIN_Q30));
    cor_y0   = '0;
    cor_z0   = '0;
    case (state_q)
      S_QAW: begin
        cor_ctrl.start = 1'b1;
        cor_z0 = signed'(ZW'(prod[30:0]));
      end
      S_KR: begin
        cor_ctrl.start = 1'b1;
        cor_z0 = signed'(ZW'(ang_q));
      end
      S_QBX: begin
        cor_ctrl.start    = 1'b1;
        cor_ctrl.vec_mode = 1'b1;
        cor_x0 = signed'(CW'(vx_q));
        cor_y0 = signed'(CW'(prod[62:16]));
      end
      default: begin
        cor_ctrl = '0;
      end
    endcase
  end

  // final combine of the quadrant pieces
  always_comb begin
    per50 = 50'(per_q);
    q50   = 50'(per_q[34:2]);
    mir50 = (q50 > arc_q) ? (q50 - arc_q) : 50'd0;
    case (region_q)
      R_ZERO: len50 = '0;
      R_ARC1: len50 = arc_q;
      R_Q90:  len50 = q50;
      R_ARC2: len50 = q50 + mir50;
      R_H180: len50 = per50 >> 1;
      R_ARC3: len50 = (per50 >> 1) + arc_q;
      R_Q270: len50 = ((per50 << 1) + per50) >> 2;
      R_ARC4: len50 = (((per50 << 1) + per50) >> 2) + mir50;
      R_FULL: len50 = per50;
      default: len50 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      region_q    <= R_ZERO;
      steps_q     <= STEPS_RESET;
      tol_q       <= TOL_RESET;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_STEPS: steps_q <= cfg_data_i[12:0];
          CFG_TOL:   tol_q   <= cfg_data_i;
          default:   ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            a_q   <= semi_major_i;
            b_q   <= semi_minor_i;
            deg_q <= (sweep_degrees_i > 9'd360) ? 9'd360 : sweep_degrees_i;
            if (semi_major_i <= semi_minor_i) begin
              inv_q   <= 1'b1;
              len_q   <= LEN_ONE;
              state_q <= S_OUT;
            end else begin
              inv_q   <= 1'b0;
              state_q <= S_PC;
            end
          end
        end
        S_PC:  state_q <= S_PC2;
        S_PC2: begin
          c_q     <= prod[62:28];
          state_q <= S_PR;
        end
        S_PR: begin
          if (div_st.done) begin
            r_q     <= div_quot[29:0];
            state_q <= S_PR2;
          end
        end
        S_PR2: state_q <= S_PR3;
        S_PR3: begin
          e2_q    <= ONE_Q30 - 31'(prod[59:30]);
          p_q     <= ONE_Q30;
          epow_q  <= ONE_Q30;
          per_q   <= c_q;
          i_q     <= TERM_W'(1);
          state_q <= S_P1;
        end
        S_P1:  state_q <= S_P1W;
        S_P1W: state_q <= S_P1D;
        S_P1D: begin
          if (div_st.done) begin
            p_q     <= div_quot[30:0];
            state_q <= S_P2;
          end
        end
        S_P2:  state_q <= S_P2W;
        S_P2W: state_q <= S_P2D;
        S_P2D: begin
          if (div_st.done) begin
            p_q     <= div_quot[30:0];
            state_q <= S_E;
          end
        end
        S_E:  state_q <= S_EW;
        S_EW: begin
          epow_q  <= prod[60:30];
          state_q <= S_PE;
        end
        S_PE:  state_q <= S_PEW;
        S_PEW: begin
          f_q     <= prod[60:30];
          state_q <= S_T1;
        end
        S_T1:  state_q <= S_T1W;
        S_T1W: begin
          tlo_q   <= prod[59:30];
          state_q <= S_T2W;
        end
        S_T2W: state_q <= S_TD;
        S_TD: begin
          if (div_st.done) begin
            per_q <= (36'(per_q) > term) ? 35'(36'(per_q) - term) : 35'd0;
            if ((term <= 36'(tol_q)) || (i_q == TERM_W'(MAX_SERIES_TERMS))) begin
              state_q <= S_DISP;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_P1;
            end
          end
        end
        S_DISP: begin
          first_q <= 1'b1;
          if (deg_q == 9'd0) begin
            region_q <= R_ZERO;
            state_q  <= S_FIN;
          end else if (deg_q < 9'd90) begin
            region_q <= R_ARC1;
            qd_q     <= deg_q[6:0];
            state_q  <= S_QA;
          end else if (deg_q == 9'd90) begin
            region_q <= R_Q90;
            state_q  <= S_FIN;
          end else if (deg_q < 9'd180) begin
            region_q <= R_ARC2;
            qd_q     <= 7'(9'd180 - deg_q);
            state_q  <= S_QA;
          end else if (deg_q == 9'd180) begin
            region_q <= R_H180;
            state_q  <= S_FIN;
          end else if (deg_q < 9'd270) begin
            region_q <= R_ARC3;
            qd_q     <= 7'(deg_q - 9'd180);
            state_q  <= S_QA;
          end else if (deg_q == 9'd270) begin
            region_q <= R_Q270;
            state_q  <= S_FIN;
          end else if (deg_q < 9'd360) begin
            region_q <= R_ARC4;
            qd_q     <= 7'(9'd360 - deg_q);
            state_q  <= S_QA;
          end else begin
            region_q <= R_FULL;
            state_q  <= S_FIN;
          end
        end
        S_QA:  state_q <= S_QAW;
        S_QAW: state_q <= S_ROT;
        S_ROT: begin
          if (cor_st.done) begin
            cos_q   <= cos_c;
            sin_q   <= sin_c;
            state_q <= S_QB;
          end
        end
        S_QB:  state_q <= S_QBW;
        S_QBW: begin
          vx_q    <= prod[62:16];
          state_q <= S_QBX;
        end
        S_QBX: state_q <= S_VEC;
        S_VEC: begin
          if (cor_st.done) begin
            if (first_q) begin
              // end angle of the integral, then start the sample loop
              t_q     <= t_c;
              first_q <= 1'b0;
              k_q     <= '0;
              sum_q   <= '0;
              state_q <= S_K;
            end else begin
              state_q <= S_M;
            end
          end
        end
        S_K:  state_q <= S_KW;
        S_KW: state_q <= S_KD;
        S_KD: begin
          if (div_st.done) begin
            ang_q   <= div_quot[30:0];
            state_q <= S_KR;
          end
        end
        S_KR: state_q <= S_ROT;
        S_M:  state_q <= S_M2;
        S_M2: begin
          mlo_q   <= prod[59:30];
          state_q <= S_M3;
        end
        S_M3: begin
          sum_q <= sum_q + mag;
          k_q   <= k_q + 1'b1;
          if ((k_q + 13'd1) == n_w) begin
            state_q <= S_F;
          end else begin
            state_q <= S_K;
          end
        end
        S_F: state_q <= S_FD;
        S_FD: begin
          if (div_st.done) begin
            sq_q    <= div_quot;
            state_q <= S_F1;
          end
        end
        S_F1: state_q <= S_F2;
        S_F2: begin
          flo_q   <= prod[60:30];
          state_q <= S_F3;
        end
        S_F3: begin
          arc_q   <= 50'((prod + 64'(flo_q)) >> 14);
          state_q <= S_FIN;
        end
        S_FIN: begin
          len_q   <= len50[37:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_len_q   <= len_q;
            out_inv_q   <= inv_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign arc_length_o   = out_len_q;
  assign axes_invalid_o = out_inv_q;

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_st.busy && !cor_st.busy)
    else $error("shared unit busy while idle");

  a_invalid_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && axes_invalid_o |-> arc_length_o == LEN_ONE)
    else $error("invalid axes result is not 1.0");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer stayed idle after a request");

  a_div_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_PR || state_q == S_P1D || state_q == S_P2D ||
                     state_q == S_TD || state_q == S_KD || state_q == S_FD))
    else $error("divider finished with no state waiting on it");

  a_cordic_done_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_st.done |-> (state_q == S_ROT || state_q == S_VEC))
    else $error("cordic finished with no state waiting on it");

endmodule
